### src/bpfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the page frame allocator.
package bpfa_pkg;

    // Allocator geometry; PAGE_BYTES is a power of two
    localparam int NUM_FRAMES = 2048;
    localparam int PAGE_BYTES = 4096;
    localparam int WORDS      = (NUM_FRAMES + 31) / 32;
    localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRAME_W    = WORD_AW + 5;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [31:0] BASE_RESET   = 32'h0080_0000;
    localparam logic [31:0] ALL_USED     = 32'hffff_ffff;
    localparam logic [32:0] NUM_FRAMES_X = 33'(NUM_FRAMES);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    // Bits beyond the last frame in the final word count as used
    localparam logic [31:0] LAST_PAD = (NUM_FRAMES % 32 == 0) ? 32'h0 :
        ~((32'h1 << (NUM_FRAMES % 32)) - 32'h1);

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NO_FREE   = 2'd1;
    localparam status_t ST_MISALIGN  = 2'd2;
    localparam status_t ST_OUT_RANGE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;        // capture request, reset scan pointer
        logic    rd_en;       // read one bitmap word
        logic    rd_free;     // read address comes from the freed frame
        logic    wr_alloc;    // write back word with the found bit set
        logic    wr_free;     // write back word with the frame bit cleared
        logic    emit;        // load the result registers
        status_t emit_status;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op;
        logic data_vld;
        logic has_free;
        logic chk_last;
        logic misaligned;
        logic out_range;
    } dp_stat_t;

endpackage

### src/bpfa_datapath.sv
// Bitmap memory, request registers, word search and result registers.
module bpfa_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    input  logic                req_opcode,
    input  logic [31:0]         req_page_address,
    input  bpfa_pkg::ctl_cmd_t  cmd,
    output bpfa_pkg::dp_stat_t  stat,
    output logic [31:0]         result_address,
    output logic [1:0]          status
);
    import bpfa_pkg::*;

    logic [31:0]        mem [WORDS];
    logic [WORDS-1:0]   valid_reg;
    logic [31:0]        base_reg;
    logic               op_reg;
    logic [31:0]        offset_reg;
    logic [WORD_AW-1:0] scan_addr_reg;
    logic [WORD_AW-1:0] scan_addr_next;
    logic [WORD_AW-1:0] chk_addr_reg;
    logic [31:0]        rdata_reg;
    logic               word_vld_reg;
    logic               data_vld_reg;
    logic [31:0]        result_address_reg;
    status_t            status_reg;

    logic [WORD_AW-1:0] rd_addr;
    logic [FRAME_W-1:0] free_frame;
    logic [31:0]        word_eff;
    logic [31:0]        masked;
    logic [4:0]         free_bit;
    logic [FRAME_W-1:0] alloc_frame;
    logic [31:0]        alloc_addr;
    logic [31:0]        wdata;
    logic               wr_en;

    // Frame named by a free request
    assign free_frame = FRAME_W'(offset_reg >> PAGE_SHIFT);

    assign rd_addr        = cmd.rd_free ? free_frame[FRAME_W-1:5] : scan_addr_reg;
    assign scan_addr_next = scan_addr_reg + WORD_AW'(1);

    // Unwritten words read as all free
    assign word_eff = word_vld_reg ? rdata_reg : 32'h0;
    assign masked   = (chk_addr_reg == LAST_WORD) ? (word_eff | LAST_PAD) : word_eff;

    // Find the lowest free bit of the checked word
    always_comb
    begin
        free_bit = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                free_bit = 5'(i);
            end
        end
    end

    assign alloc_frame = {chk_addr_reg, free_bit};
    assign alloc_addr  = base_reg + (32'(alloc_frame) << PAGE_SHIFT);

    assign wr_en = cmd.wr_alloc | cmd.wr_free;
    assign wdata = cmd.wr_alloc ? (word_eff | (32'h1 << free_bit))
                                : (word_eff & ~(32'h1 << free_frame[4:0]));

    // Status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.data_vld   = data_vld_reg;
        stat.has_free   = (masked != ALL_USED);
        stat.chk_last   = (chk_addr_reg == LAST_WORD);
        stat.misaligned = (offset_reg[PAGE_SHIFT-1:0] != '0);
        stat.out_range  = ({1'b0, offset_reg >> PAGE_SHIFT} >= NUM_FRAMES_X);
    end

    // Hold base register, valid bits and read-data flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            valid_reg    <= '0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[chk_addr_reg] <= 1'b1;
            end
            data_vld_reg <= cmd.rd_en;
        end
    end

    // Capture request, advance scan pointer, read bitmap word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= req_opcode;
            offset_reg    <= req_page_address - base_reg;
            scan_addr_reg <= '0;
        end
        else if (cmd.rd_en && !cmd.rd_free)
        begin
            scan_addr_reg <= scan_addr_next;
        end
        if (cmd.rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            word_vld_reg <= valid_reg[rd_addr];
            chk_addr_reg <= rd_addr;
        end
    end

    // Write back updated bitmap word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[chk_addr_reg] <= wdata;
        end
    end

    // Load result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_address_reg <= cmd.wr_alloc ? alloc_addr : 32'h0;
            status_reg         <= cmd.emit_status;
        end
    end

    assign result_address = result_address_reg;
    assign status         = status_reg;

endmodule

### src/bpfa_ctrl.sv
// Request sequencer: scan for allocation, read-modify-write for free, result strobe.
module bpfa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                idle,
    output logic                done,
    input  bpfa_pkg::dp_stat_t  stat,
    output bpfa_pkg::ctl_cmd_t  cmd
);
    import bpfa_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_SCAN     = 2'd1;
    localparam logic [1:0] S_FREE_CHK = 2'd2;
    localparam logic [1:0] S_FREE_WR  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    assign busy = (state_reg != S_IDLE);
    assign idle = (state_reg == S_IDLE);
    assign done = done_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.op == OP_FREE)
                begin
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    if (stat.data_vld && stat.has_free)
                    begin
                        cmd.wr_alloc = 1'b1;
                        cmd.emit     = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (stat.data_vld && stat.chk_last)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NO_FREE;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_FREE_CHK:
            begin
                if (stat.misaligned)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_MISALIGN;
                    state_next      = S_IDLE;
                end
                else if (stat.out_range)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OUT_RANGE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_free = 1'b1;
                    state_next  = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                cmd.rd_free = 1'b1;
                cmd.wr_free = 1'b1;
                cmd.emit    = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state, register the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

endmodule

### src/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator.
//
//   channel   transfer when              ports
//   -------   ------------------------   ----------------------------------
//   request   start && !busy             opcode, page_address
//   result    done (one cycle strobe)    result_address, status
//   config    cfg_valid && cfg_ready     base_address
//
// Allocate: the request is taken, then the scan reads one bitmap word per cycle
// from the single read port; each word is registered before it is checked, and
// the scan stops at the first word with a free frame or after the last word.
// Free: dispatch, check with word read, write back, result strobe; a rejected
// address skips the word read and write back.
// Reset clears the bitmap at once through per-word valid bits; no sweep.
// done is high for one cycle only; the receiver cannot stall it.
module bitmap_page_frame_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] page_address,
    output logic        done,
    output logic [31:0] result_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] base_address
);
    import bpfa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     idle;

    // Accept configuration only between requests, never beside a request transfer
    assign cfg_ready = idle & ~start;

    bpfa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .idle  (idle),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    bpfa_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_data         (base_address),
        .req_opcode       (opcode),
        .req_page_address (page_address),
        .cmd              (cmd),
        .stat             (stat),
        .result_address   (result_address),
        .status           (status)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap page frame allocator: directed, fill and random tests.
module testbench;
    import bpfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 2 * (WORDS + 2);
    localparam int PHASE_ITEMS    = 155;
    localparam int FILL_ITEMS     = 600;
    localparam int PRINT_LIMIT    = 100;
    localparam logic [31:0] FRAME_SPAN = 32'(PAGE_BYTES);
    localparam logic [31:0] FRAME_CNT  = 32'(NUM_FRAMES);

    typedef struct packed {
        logic [31:0] addr;
        status_t     st;
    } page_result_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        opcode       = OP_ALLOC;
    logic [31:0] page_address = 32'h0;
    logic        cfg_valid    = 1'b0;
    logic [31:0] base_address = 32'h0;
    logic        busy;
    logic        done;
    logic [31:0] result_address;
    logic [1:0]  status;
    logic        cfg_ready;

    // Shadow copy of the allocator state
    logic [31:0]  frame_map [WORDS];
    logic [31:0]  cur_base;
    page_result_t pending_results [$];
    int           held_frames [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           burst_left  = 0;
    bit           allow_gaps  = 1'b1;

    bitmap_page_frame_allocator u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .page_address   (page_address),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .base_address   (base_address)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
        begin
            $display("%0t ERROR: %s", $time, what);
        end
        error_count++;
    endtask

    // Compute the result of one request and update the shadow bitmap
    function automatic page_result_t predict_page_op(input logic op, input logic [31:0] addr,
                                                     output int frame_idx);
        page_result_t r;
        logic [31:0]  offset;
        r = '{addr: 32'h0, st: ST_NO_FREE};
        frame_idx = -1;
        if (op == OP_ALLOC)
        begin
            // claim the lowest-numbered free frame
            for (int f = 0; f < NUM_FRAMES && frame_idx < 0; f++)
            begin
                if (!frame_map[f / 32][f % 32])
                begin
                    frame_idx = f;
                end
            end
            if (frame_idx >= 0)
            begin
                frame_map[frame_idx / 32][frame_idx % 32] = 1'b1;
                r.addr = cur_base + 32'(frame_idx) * FRAME_SPAN;
                r.st   = ST_OK;
            end
        end
        else
        begin
            // alignment is checked before range; the offset wraps below base
            offset = addr - cur_base;
            if (offset % FRAME_SPAN != 32'h0)
            begin
                r.st = ST_MISALIGN;
            end
            else if (offset / FRAME_SPAN >= FRAME_CNT)
            begin
                r.st = ST_OUT_RANGE;
            end
            else
            begin
                frame_idx = int'(offset / FRAME_SPAN);
                frame_map[frame_idx / 32][frame_idx % 32] = 1'b0;
                r.st = ST_OK;
            end
        end
        return r;
    endfunction

    // Drive one request and hold it until the transfer; start stays high afterwards
    task automatic send_request(input logic op, input logic [31:0] addr);
        page_result_t r;
        int           frame_idx;
        start        <= 1'b1;
        opcode       <= op;
        page_address <= addr;
        do @(posedge clk); while (busy);
        r = predict_page_op(op, addr, frame_idx);
        pending_results.push_back(r);
        if (op == OP_ALLOC && r.st == ST_OK)
        begin
            held_frames.push_back(frame_idx);
        end
    endtask

    // Insert a random gap between bursts of requests
    task automatic pace_requests();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = allow_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Write the base register once all results are in
    task automatic write_base(input logic [31:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        base_address <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = value;
    endtask

    function automatic logic [31:0] frame_address(input int f);
        return cur_base + 32'(f) * FRAME_SPAN;
    endfunction

    // Free addresses that are misaligned, out of range, in range but perhaps unheld, or simply arbitrary
    function automatic logic [31:0] stray_address();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return frame_address($urandom_range(0, NUM_FRAMES - 1)) +
                      32'($urandom_range(1, PAGE_BYTES - 1));
            2: return frame_address($urandom_range(0, NUM_FRAMES - 1));
            3: return frame_address(NUM_FRAMES + $urandom_range(0, 1000));
            default: return cur_base - 32'($urandom_range(1, 1000)) * FRAME_SPAN;
        endcase
    endfunction

    task automatic test_directed();
        // reset base, lowest-first allocation and every free error
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, cur_base);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, cur_base + 32'h1);
        send_request(OP_FREE, cur_base + FRAME_SPAN / 2);
        send_request(OP_FREE, cur_base - FRAME_SPAN);
        send_request(OP_FREE, frame_address(NUM_FRAMES));
        send_request(OP_FREE, frame_address(NUM_FRAMES) + 32'h1);
        send_request(OP_FREE, frame_address(NUM_FRAMES - 1));
        send_request(OP_FREE, 32'h0);
        send_request(OP_FREE, 32'hffff_ffff);
        send_request(OP_ALLOC, 32'hffff_ffff);
        // base near the top of the address space: results wrap
        write_base(32'hffff_f000);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, frame_address(2));
        send_request(OP_FREE, cur_base - FRAME_SPAN);
        write_base(32'h0);
        send_request(OP_FREE, 32'h0);
        send_request(OP_ALLOC, 32'h0);
    endtask

    task automatic test_fill();
        // allocate a long run, then reopen scattered holes
        repeat (FILL_ITEMS)
        begin
            pace_requests();
            send_request(OP_ALLOC, $urandom);
        end
        send_request(OP_FREE, frame_address(NUM_FRAMES - 1));
        send_request(OP_FREE, frame_address(40));
        send_request(OP_FREE, frame_address(31));
        send_request(OP_FREE, frame_address(32));
        repeat (5)
        begin
            pace_requests();
            send_request(OP_ALLOC, 32'h0);
        end
    endtask

    task automatic test_random();
        logic [31:0] bases [6];
        int          pick;
        int          k;
        int          f;
        bases[0] = 32'hffff_f000;
        bases[1] = 32'hffff_ffff;
        bases[2] = $urandom & ~(FRAME_SPAN - 32'h1);
        bases[3] = $urandom;
        bases[4] = BASE_RESET;
        bases[5] = 32'h0;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_base(bases[phase]);
            allow_gaps = (phase % 2 == 0);
            burst_left = 0;
            repeat (PHASE_ITEMS)
            begin
                pace_requests();
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    send_request(OP_ALLOC, $urandom);
                end
                else if (pick < 85 && held_frames.size() > 0)
                begin
                    // release a frame handed out earlier
                    k = $urandom_range(0, held_frames.size() - 1);
                    f = held_frames[k];
                    held_frames.delete(k);
                    send_request(OP_FREE, frame_address(f));
                end
                else
                begin
                    send_request(OP_FREE, stray_address());
                end
            end
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        page_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result addr %h status %0d",
                                          result_address, status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_address !== want.addr)
                begin
                    report_mismatch($sformatf("result_address %h, expected %h",
                                              result_address, want.addr));
                end
                if (status !== want.st)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                end
            end
        end
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (frame_map[i])
        begin
            frame_map[i] = 32'h0;
        end
        cur_base = BASE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill();
        test_random();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### bitmap_page_frame_allocator.f
src/bpfa_pkg.sv
src/bpfa_datapath.sv
src/bpfa_ctrl.sv
src/bitmap_page_frame_allocator.sv
verif/testbench.sv
